// ===== hw/rtl/qars_pkg.sv =====
package qars_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int TERM_W      = 9;
    localparam int SUM_W       = 19;
    localparam int INDEX_W     = 20;
    localparam int DIM_W       = 11;
    localparam int AXIS_W      = 2;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    // output queue, three slots keep one transfer per cycle with a registered tready
    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 2;
    localparam int OCC_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_AXIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd4;

    // reduce_axis codes
    localparam logic [AXIS_W-1:0] AXIS_NONE    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_HEIGHT  = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_WIDTH   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_CHANNEL = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]     result_index;
        logic signed [SUM_W-1:0] result_sum;
        logic                   tensor_done;
    } result_t;

endpackage

// ===== hw/rtl/quantized_axis_reduce_sum.sv =====
// Streaming int8 reduce-sum over one axis of an HWC tensor. Takes one sample per cycle while
// the output buffer has room, from an accumulator memory with one read port and one write port:
// each sample is read in the cycle it is accepted and its updated sum is written back the next
// cycle, with the last written entry forwarded so back-to-back samples hitting the same entry
// see the fresh value. A completed sum is pushed into a three-slot output buffer in the cycle
// after its last sample is accepted and is offered on m_axis from there; s_axis_tready drops
// only when that buffer is backed up. The accumulator needs no clearing after reset because
// the first term of every sum overwrites its entry. Channel sums (axis 3) use a register
// instead of the memory. Registers may only be written while no samples are in flight.
module quantized_axis_reduce_sum #(
    parameter int MAX_DIM   = 1024,
    parameter int ACC_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [qars_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [qars_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [18:0] result_sum,
                                                                 // [38:19] result_index, [39] 0
    output logic                                 m_axis_tlast,   // tensor_done
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qars_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qars_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam logic [qars_pkg::PROD_W-1:0] ACC_LIM = qars_pkg::PROD_W'(ACC_DEPTH);

    // configuration
    logic [qars_pkg::DIM_W-1:0]         height_reg, width_reg, channels_reg;
    logic [qars_pkg::AXIS_W-1:0]        axis_reg;
    logic signed [qars_pkg::SAMPLE_W-1:0] zero_reg;

    // position counters
    logic [qars_pkg::DIM_W-1:0]   row_reg, col_reg, chan_reg;
    logic [qars_pkg::INDEX_W-1:0] emit_idx_reg;

    // accumulator stage
    logic                                 s1_valid_reg;
    logic                                 s1_emit_reg;
    logic                                 s1_wr_reg;
    logic                                 s1_pix_reg;
    logic                                 s1_first_reg;
    logic                                 s1_done_reg;
    logic signed [qars_pkg::TERM_W-1:0]   s1_term_reg;
    logic [AW-1:0]                        s1_addr_reg;
    logic [qars_pkg::INDEX_W-1:0]         s1_index_reg;
    logic signed [qars_pkg::SUM_W-1:0]    pixel_sum_reg;

    logic signed [qars_pkg::SUM_W-1:0]    acc_mem [ACC_DEPTH];
    logic signed [qars_pkg::SUM_W-1:0]    rd_data_reg;
    logic signed [qars_pkg::SUM_W-1:0]    fwd_data_reg;
    logic [AW-1:0]                        fwd_addr_reg;
    logic                                 fwd_valid_reg;

    // output queue
    qars_pkg::result_t             q_reg [qars_pkg::Q_DEPTH];
    logic [qars_pkg::Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [qars_pkg::Q_CNT_W-1:0]  q_cnt_reg;

    function automatic logic [qars_pkg::DIM_W-1:0] clamp_dim(input logic [qars_pkg::DIM_W-1:0] v);
        logic [qars_pkg::DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = qars_pkg::DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = qars_pkg::DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    logic [qars_pkg::DIM_W-1:0]          hd, wd, cd;
    logic                                last_c, last_w, last_h, done;
    logic signed [qars_pkg::TERM_W-1:0]  term;
    logic [qars_pkg::PROD_W-1:0]         plane_size, col_base, addr_h;
    logic                                ok_w, ok_h;
    logic                                emit, mem_wr, first, pix;
    logic [AW-1:0]                       addr;
    logic                                accept;

    assign hd = clamp_dim(height_reg);
    assign wd = clamp_dim(width_reg);
    assign cd = clamp_dim(channels_reg);

    assign last_c = ({1'b0, chan_reg} + 1'b1) >= {1'b0, cd};
    assign last_w = ({1'b0, col_reg} + 1'b1) >= {1'b0, wd};
    assign last_h = ({1'b0, row_reg} + 1'b1) >= {1'b0, hd};
    assign done   = last_c && last_w && last_h;

    assign term = $signed({s_axis_tdata[qars_pkg::SAMPLE_W-1], s_axis_tdata})
                - $signed({zero_reg[qars_pkg::SAMPLE_W-1], zero_reg});

    assign plane_size = qars_pkg::PROD_W'(wd) * qars_pkg::PROD_W'(cd);
    assign col_base   = qars_pkg::PROD_W'(col_reg) * qars_pkg::PROD_W'(cd);
    assign addr_h     = col_base + qars_pkg::PROD_W'(chan_reg);

    assign ok_w = (qars_pkg::PROD_W'(cd) <= ACC_LIM) && (qars_pkg::PROD_W'(chan_reg) < ACC_LIM);
    assign ok_h = (plane_size <= ACC_LIM) && (addr_h < ACC_LIM);

    always_comb
    begin
        emit   = 1'b0;
        mem_wr = 1'b0;
        first  = 1'b0;
        pix    = 1'b0;
        addr   = addr_h[AW-1:0];
        unique case (axis_reg)
            qars_pkg::AXIS_CHANNEL:
            begin
                pix   = 1'b1;
                first = (chan_reg == '0);
                emit  = last_c;
            end
            qars_pkg::AXIS_WIDTH:
            begin
                addr   = AW'(chan_reg);
                first  = (col_reg == '0);
                mem_wr = ok_w;
                emit   = ok_w && last_w;
            end
            qars_pkg::AXIS_HEIGHT:
            begin
                first  = (row_reg == '0);
                mem_wr = ok_h;
                emit   = ok_h && last_h;
            end
            qars_pkg::AXIS_NONE:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= qars_pkg::DIM_W'(1);
            width_reg    <= qars_pkg::DIM_W'(1);
            channels_reg <= qars_pkg::DIM_W'(1);
            axis_reg     <= qars_pkg::AXIS_CHANNEL;
            zero_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qars_pkg::REG_HEIGHT:      height_reg   <= cfg_data;
                qars_pkg::REG_WIDTH:       width_reg    <= cfg_data;
                qars_pkg::REG_CHANNELS:    channels_reg <= cfg_data;
                qars_pkg::REG_REDUCE_AXIS: axis_reg     <= cfg_data[qars_pkg::AXIS_W-1:0];
                qars_pkg::REG_ZERO_OFFSET: zero_reg     <= $signed(cfg_data[qars_pkg::SAMPLE_W-1:0]);
                default:                   ;
            endcase
        end
    end

    // input side, throttled by how full the output queue may become
    logic [qars_pkg::OCC_W-1:0] occ;
    assign occ           = qars_pkg::OCC_W'(q_cnt_reg) + qars_pkg::OCC_W'(s1_valid_reg);
    assign s_axis_tready = (occ < qars_pkg::OCC_W'(qars_pkg::Q_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            chan_reg     <= '0;
            emit_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                if (last_c)
                begin
                    chan_reg <= '0;
                    if (last_w)
                    begin
                        col_reg <= '0;
                        row_reg <= last_h ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                else
                begin
                    chan_reg <= chan_reg + 1'b1;
                end
                if (done)
                begin
                    emit_idx_reg <= '0;
                end
                else if (emit)
                begin
                    emit_idx_reg <= emit_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit;
            s1_wr_reg    <= mem_wr;
            s1_pix_reg   <= pix;
            s1_first_reg <= first;
            s1_done_reg  <= done;
            s1_term_reg  <= term;
            s1_addr_reg  <= addr;
            s1_index_reg <= emit_idx_reg;
        end
    end

    // read-modify-write
    logic signed [qars_pkg::SUM_W-1:0] base, sum;
    logic                              fwd_hit;

    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);

    always_comb
    begin
        priority if (s1_pix_reg)
        begin
            base = pixel_sum_reg;
        end
        else if (fwd_hit)
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rd_data_reg;
        end
        sum = (s1_first_reg ? '0 : base)
            + {{(qars_pkg::SUM_W - qars_pkg::TERM_W){s1_term_reg[qars_pkg::TERM_W-1]}},
               s1_term_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= acc_mem[addr];
        end
        if (s1_valid_reg && s1_wr_reg)
        begin
            acc_mem[s1_addr_reg] <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            pixel_sum_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_wr_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_pix_reg)
            begin
                pixel_sum_reg <= sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_wr_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= sum;
        end
    end

    // output queue
    logic push, pop;
    qars_pkg::result_t head;

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = q_reg[rd_ptr_reg];

    assign m_axis_tvalid = (q_cnt_reg != '0);
    assign m_axis_tdata  = {1'b0, head.result_index, head.result_sum};
    assign m_axis_tlast  = head.tensor_done;

    function automatic logic [qars_pkg::Q_PTR_W-1:0] ptr_inc(input logic [qars_pkg::Q_PTR_W-1:0] p);
        return (p == qars_pkg::Q_PTR_W'(qars_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            q_cnt_reg <= q_cnt_reg + qars_pkg::Q_CNT_W'(push) - qars_pkg::Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].result_sum   <= sum;
            q_reg[wr_ptr_reg].result_index <= s1_index_reg;
            q_reg[wr_ptr_reg].tensor_done  <= s1_done_reg;
        end
    end

endmodule
